[rtl/sse_pkg.sv]
// shared constants, opcodes and types of the sorted set engine
package sse_pkg;
	localparam int NumSetsDef      = 16;
	localparam int SetCapacityDef  = 64;
	localparam int ElementWidthDef = 32;

	localparam logic [3:0] OP_INSERT = 4'd0;
	localparam logic [3:0] OP_DELETE = 4'd1;
	localparam logic [3:0] OP_MEMBER = 4'd2;
	localparam logic [3:0] OP_UNION  = 4'd3;
	localparam logic [3:0] OP_INTER  = 4'd4;
	localparam logic [3:0] OP_SIZE   = 4'd5;
	localparam logic [3:0] OP_DIFF   = 4'd6;
	localparam logic [3:0] OP_SYMD   = 4'd7;
	localparam logic [3:0] OP_LIST   = 4'd8;

	// control from the sequencer to the element memory
	typedef struct packed {
		logic a_rd;
		logic b_rd;
		logic wr;
	} mem_ctl_t;
endpackage

[rtl/sse_mem.sv]
// element memory: one write port and two registered read ports
module sse_mem import sse_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int EW    = 32
) (
	input  logic                     clk,
	input  mem_ctl_t                 ctl,
	input  logic [$clog2(DEPTH)-1:0] a_addr,
	input  logic [$clog2(DEPTH)-1:0] b_addr,
	input  logic [$clog2(DEPTH)-1:0] w_addr,
	input  logic [EW-1:0]            w_data,
	output logic [EW-1:0]            a_data,
	output logic [EW-1:0]            b_data
);
	logic [EW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) mem[w_addr] <= w_data;
		if (ctl.a_rd) a_data <= mem[a_addr];
		if (ctl.b_rd) b_data <= mem[b_addr];
	end
endmodule

[rtl/sse_buf.sv]
// merge scratch buffer, one write and one registered read a cycle
module sse_buf import sse_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int EW    = 32
) (
	input  logic                     clk,
	input  logic                     wr,
	input  logic [$clog2(DEPTH)-1:0] w_addr,
	input  logic [EW-1:0]            w_data,
	input  logic                     rd,
	input  logic [$clog2(DEPTH)-1:0] r_addr,
	output logic [EW-1:0]            r_data
);
	logic [EW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr) mem[w_addr] <= w_data;
		if (rd) r_data <= mem[r_addr];
	end
endmodule

[rtl/sorted_set_engine.sv]
// top level of the sorted set engine: sequencer, sizes and result register
// The block keeps NUM_SETS sorted sets of up to SET_CAPACITY signed elements in
// one element memory (two registered read ports, one write port) with set
// sizes held in flip-flops that reset clears. One input word is handled at a
// time; the input is not ready until its last result word has been taken.
// Insert, delete and member scan the target set linearly, each entry read
// (SCAN) and then compared (SCANW), and insert/delete then shift entries one
// per cycle after a priming read of the first entry to move. Union,
// intersection, difference and symmetric difference read the heads of both
// sets (MRD, MWT), then walk them in step, one step per cycle taking the
// smaller head or both equal heads, into a scratch buffer and copy it back.
// Size and list each wait on the output handshake, list once per element.
// Unknown opcodes and out of range target sets are dropped with no result. A
// second set index out of range acts as an empty set. Memory contents need no
// clearing after reset.
module sorted_set_engine import sse_pkg::*; #(
	parameter int NUM_SETS      = NumSetsDef,
	parameter int SET_CAPACITY  = SetCapacityDef,
	parameter int ELEMENT_WIDTH = ElementWidthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// opcode[3:0], set_index[7:4], other_set[11:8], value[43:12], zero fill
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// count[6:0], element[38:7], has_element[39], overflow[40], zero fill
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	localparam int SW = $clog2(NUM_SETS);
	localparam int PW = $clog2(SET_CAPACITY);
	localparam int CW = PW + 1;
	localparam int AW = SW + PW;
	localparam int EW = ELEMENT_WIDTH;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_SCANW = 4'd2;
	localparam logic [3:0] ST_SHIFT = 4'd3;
	localparam logic [3:0] ST_MRD   = 4'd4;
	localparam logic [3:0] ST_MRG   = 4'd5;
	localparam logic [3:0] ST_CPY   = 4'd6;
	localparam logic [3:0] ST_LRD   = 4'd7;
	localparam logic [3:0] ST_LOUT  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_MWT   = 4'd10;

	logic [3:0]    state_q;
	logic [CW-1:0] size_q [NUM_SETS];
	logic [3:0]    op_q;
	logic [SW-1:0] s_q, o_q;
	logic          o_ok_q;
	logic [EW-1:0] v_q;
	logic [CW-1:0] i_q, j_q, n_q, na_q, nb_q;
	logic          ovf_q, fnd_q, rdv_q;
	logic          out_v_q, out_last_q, out_has_q, out_ovf_q;
	logic [6:0]    out_cnt_q;
	logic [31:0]   out_el_q;

	mem_ctl_t      mctl;
	logic [AW-1:0] a_addr, b_addr, w_addr;
	logic [EW-1:0] w_data, a_data, b_data, buf_r;
	logic          buf_wr, buf_rd;
	logic [PW-1:0] buf_wa, buf_ra;

	logic [3:0]    in_op;
	logic [3:0]    in_si, in_oi;
	logic [31:0]   in_val;
	assign in_op  = s_axis_tdata[3:0];
	assign in_si  = s_axis_tdata[7:4];
	assign in_oi  = s_axis_tdata[11:8];
	assign in_val = s_axis_tdata[43:12];

	function automatic logic [EW-1:0] fit(input logic [31:0] x);
		logic [63:0] se;
		se = {{32{x[31]}}, x};
		return se[EW-1:0];
	endfunction

	function automatic logic [AW-1:0] adr(input logic [SW-1:0] s, input logic [CW-1:0] p);
		return {s, p[PW-1:0]};
	endfunction

	// merge step decision
	logic          a_more, b_more, take_a, take_b, keep;
	logic [EW-1:0] mx;
	assign a_more = i_q < na_q;
	assign b_more = j_q < nb_q;
	always_comb begin
		take_a = 1'b0;
		take_b = 1'b0;
		if (!b_more || (a_more && $signed(a_data) < $signed(b_data))) take_a = 1'b1;
		else if (!a_more || $signed(b_data) < $signed(a_data)) take_b = 1'b1;
		mx = take_b ? b_data : a_data;
		case (op_q)
			OP_UNION: keep = 1'b1;
			OP_INTER: keep = !take_a && !take_b;
			OP_DIFF:  keep = take_a;
			OP_SYMD:  keep = take_a || take_b;
			default:  keep = 1'b0;
		endcase
	end

	logic [CW-1:0] sz_s, i_n, j_n;
	assign sz_s = size_q[s_q];
	always_comb begin
		i_n = i_q + CW'(!take_b);
		j_n = j_q + CW'(!take_a);
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		mctl   = '0;
		a_addr = adr(s_q, i_q);
		b_addr = adr(o_q, j_q);
		w_addr = adr(s_q, i_q);
		w_data = a_data;
		buf_wr = 1'b0;
		buf_wa = n_q[PW-1:0];
		buf_rd = 1'b0;
		buf_ra = i_q[PW-1:0];
		case (state_q)
			ST_SCAN: mctl.a_rd = 1'b1;
			ST_SHIFT: begin
				if (op_q == OP_INSERT) begin
					// move entry i-1 up to i, reading one entry ahead
					a_addr    = adr(s_q, rdv_q ? i_q - CW'(2) : i_q - CW'(1));
					mctl.a_rd = 1'b1;
					mctl.wr   = rdv_q || i_q == j_q;
					w_addr    = adr(s_q, i_q);
					w_data    = (i_q == j_q) ? v_q : a_data;
				end else begin
					// move entry i+1 down to i, reading one entry ahead
					a_addr    = adr(s_q, rdv_q ? i_q + CW'(2) : i_q + CW'(1));
					mctl.a_rd = 1'b1;
					mctl.wr   = rdv_q;
					w_addr    = adr(s_q, i_q);
				end
			end
			ST_MRD: begin
				mctl.a_rd = 1'b1;
				mctl.b_rd = 1'b1;
			end
			ST_MRG: begin
				a_addr    = adr(s_q, i_n);
				b_addr    = adr(o_q, j_n);
				mctl.a_rd = 1'b1;
				mctl.b_rd = 1'b1;
				buf_wr    = keep && n_q < CW'(SET_CAPACITY);
			end
			ST_CPY: begin
				buf_rd  = 1'b1;
				mctl.wr = rdv_q;
				w_addr  = adr(s_q, j_q);
				w_data  = buf_r;
			end
			ST_LRD: mctl.a_rd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			s_q     <= '0;
			for (int k = 0; k < NUM_SETS; k++) size_q[k] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && in_op <= OP_LIST && 32'(in_si) < NUM_SETS) begin
						op_q   <= in_op;
						s_q    <= SW'(in_si);
						o_ok_q <= 32'(in_oi) < NUM_SETS;
						o_q    <= (32'(in_oi) < NUM_SETS) ? SW'(in_oi) : SW'(in_si);
						v_q    <= fit(in_val);
						i_q    <= '0;
						j_q    <= '0;
						n_q    <= '0;
						ovf_q  <= 1'b0;
						fnd_q  <= 1'b0;
						rdv_q  <= 1'b0;
						case (in_op)
							OP_SIZE: state_q <= ST_OUT;
							OP_LIST: state_q <= ST_LRD;
							OP_INSERT, OP_DELETE, OP_MEMBER: state_q <= ST_SCAN;
							default: state_q <= ST_MRD;
						endcase
					end
				end
				ST_SCAN: begin
					// issue read of entry i, flagged valid only if not past the end
					state_q <= ST_SCANW;
					rdv_q   <= i_q < sz_s;
				end
				ST_SCANW: begin
					if (rdv_q && $signed(a_data) < $signed(v_q)) begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_SCAN;
					end else begin
						fnd_q <= rdv_q && a_data == v_q;
						rdv_q <= 1'b0;
						if (op_q == OP_MEMBER) state_q <= ST_OUT;
						else if (op_q == OP_INSERT) begin
							if (rdv_q && a_data == v_q) state_q <= ST_OUT;
							else if (sz_s >= CW'(SET_CAPACITY)) begin
								ovf_q   <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								// shift from top down to position i
								j_q     <= i_q;
								i_q     <= sz_s;
								state_q <= ST_SHIFT;
							end
						end else begin
							if (rdv_q && a_data == v_q) state_q <= ST_SHIFT;
							else state_q <= ST_OUT;
						end
					end
				end
				ST_SHIFT: begin
					if (op_q == OP_INSERT) begin
						// the first cycle only primes the read of entry i-1, unless i already equals j
						if (i_q == j_q) begin
							size_q[s_q] <= sz_s + CW'(1);
							state_q     <= ST_OUT;
						end else if (!rdv_q) rdv_q <= 1'b1;
						else i_q <= i_q - CW'(1);
					end else begin
						// the first cycle only primes the read of entry i+1, unless entry i is the last
						if (rdv_q ? (i_q + CW'(2) >= sz_s) : (i_q + CW'(1) >= sz_s)) begin
							size_q[s_q] <= sz_s - CW'(1);
							state_q     <= ST_OUT;
						end else if (!rdv_q) rdv_q <= 1'b1;
						else i_q <= i_q + CW'(1);
					end
				end
				ST_MRD: begin
					na_q    <= sz_s;
					nb_q    <= o_ok_q ? size_q[o_q] : '0;
					state_q <= ST_MWT;
				end
				ST_MWT: state_q <= ST_MRG;
				ST_MRG: begin
					if (!a_more && !b_more) begin
						i_q     <= '0;
						j_q     <= '0;
						rdv_q   <= 1'b0;
						state_q <= ST_CPY;
					end else begin
						i_q <= i_n;
						j_q <= j_n;
						if (keep) begin
							if (n_q < CW'(SET_CAPACITY)) n_q <= n_q + CW'(1);
							else ovf_q <= 1'b1;
						end
					end
				end
				ST_CPY: begin
					rdv_q <= i_q < n_q;
					j_q   <= i_q;
					i_q   <= i_q + CW'(1);
					if (!(i_q < n_q)) begin
						size_q[s_q] <= n_q;
						state_q     <= ST_OUT;
					end
				end
				ST_LRD: begin
					rdv_q   <= 1'b1;
					state_q <= ST_LOUT;
				end
				ST_LOUT: begin
					if (!out_v_q && rdv_q) begin
						out_v_q    <= 1'b1;
						out_cnt_q  <= 7'(sz_s);
						out_has_q  <= sz_s != '0;
						out_el_q   <= (sz_s != '0) ? 32'($signed(a_data)) : '0;
						out_ovf_q  <= 1'b0;
						out_last_q <= sz_s == '0 || i_q + CW'(1) == sz_s;
						rdv_q      <= 1'b0;
					end else if (out_v_q && m_axis_tready) begin
						out_v_q <= 1'b0;
						if (out_last_q) state_q <= ST_IDLE;
						else begin
							i_q     <= i_q + CW'(1);
							state_q <= ST_LRD;
						end
					end
				end
				ST_OUT: begin
					if (!out_v_q) begin
						out_v_q    <= 1'b1;
						out_cnt_q  <= (op_q == OP_MEMBER) ? 7'(fnd_q) : 7'(sz_s);
						out_has_q  <= 1'b0;
						out_el_q   <= '0;
						out_ovf_q  <= ovf_q;
						out_last_q <= 1'b1;
					end else if (m_axis_tready) begin
						out_v_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sse_mem #(.DEPTH(NUM_SETS << PW), .EW(EW)) u_mem (
		.clk(clk), .ctl(mctl), .a_addr(a_addr), .b_addr(b_addr),
		.w_addr(w_addr), .w_data(w_data), .a_data(a_data), .b_data(b_data)
	);

	sse_buf #(.DEPTH(SET_CAPACITY), .EW(EW)) u_buf (
		.clk(clk), .wr(buf_wr), .w_addr(buf_wa), .w_data(mx),
		.rd(buf_rd), .r_addr(buf_ra), .r_data(buf_r)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_ovf_q, out_has_q, out_el_q, out_cnt_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("input ready with result pending");
	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		size_q[s_q] <= CW'(SET_CAPACITY)) else $error("set size beyond capacity");
	a_merge_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MRG |-> n_q <= CW'(SET_CAPACITY)) else $error("merge count overrun");
endmodule

[sim/sorted_set_engine_test.sv]
// self-checking testbench of the sorted set engine
`timescale 1ns / 100ps

module sorted_set_engine_test;
	import sse_pkg::*;

	localparam int SETS = 16;
	localparam int CAP  = 64;

	// one result word as seen on the master side
	typedef struct packed {
		logic [6:0]  count;
		logic [31:0] element;
		logic        has_element;
		logic        last;
		logic        overflow;
	} result_t;

	// directed stimulus row; a set check flag means the typed-in count and overflow are compared too
	typedef struct packed {
		logic [3:0]  op;
		logic [3:0]  si;
		logic [3:0]  oi;
		logic [31:0] val;
		logic        check;
		logic [6:0]  count;
		logic        ovf;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	// shadow copy of the set bank
	logic signed [31:0] shadow_elems [SETS][CAP];
	int                 shadow_size  [SETS];

	result_t expected_words[$];
	int      errors;
	int      words_seen;
	int      items_sent;
	int      stall_left;
	bit      quiet_tail;

	sorted_set_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("timeout at %0t", $time);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic result_t make_word(int cnt, logic [31:0] el, bit has, bit lst, bit ov);
		result_t r;
		r.count = cnt[6:0];
		r.element = el;
		r.has_element = has;
		r.last = lst;
		r.overflow = ov;
		return r;
	endfunction

	// append one expected word at the tail of the queue
	function automatic void add_expected(result_t w);
		expected_words = {expected_words, w};
	endfunction

	// merge two sets into set a; keep flags for only-a, only-b, both
	function automatic bit merge_sets(int a, int b, int nb, bit ka, bit kb, bit kboth);
		logic signed [31:0] buffer [CAP];
		logic signed [31:0] x;
		int na, i, j, n;
		bit keep, ov;
		na = shadow_size[a];
		i = 0;
		j = 0;
		n = 0;
		ov = 0;
		while (i < na || j < nb) begin
			if (j >= nb || (i < na && shadow_elems[a][i] < shadow_elems[b][j])) begin
				x = shadow_elems[a][i];
				i++;
				keep = ka;
			end else if (i >= na || shadow_elems[b][j] < shadow_elems[a][i]) begin
				x = shadow_elems[b][j];
				j++;
				keep = kb;
			end else begin
				x = shadow_elems[a][i];
				i++;
				j++;
				keep = kboth;
			end
			if (keep) begin
				if (n < CAP) begin
					buffer[n] = x;
					n++;
				end else begin
					ov = 1;
				end
			end
		end
		for (int k = 0; k < n; k++)
			shadow_elems[a][k] = buffer[k];
		shadow_size[a] = n;
		return ov;
	endfunction

	// work out the result words of one accepted input word
	function automatic void predict_set_op(logic [3:0] op, logic [3:0] si, logic [3:0] oi,
			logic signed [31:0] v);
		int s, o, ob, p, n;
		bit found, ov;
		s = si;
		o = oi;
		ob = shadow_size[o];
		ov = 0;
		if (op > OP_LIST)
			return;
		p = 0;
		while (p < shadow_size[s] && shadow_elems[s][p] < v)
			p++;
		found = p < shadow_size[s] && shadow_elems[s][p] == v;
		case (op)
			OP_INSERT: begin
				if (!found) begin
					if (shadow_size[s] >= CAP) begin
						ov = 1;
					end else begin
						for (int k = shadow_size[s]; k > p; k--)
							shadow_elems[s][k] = shadow_elems[s][k-1];
						shadow_elems[s][p] = v;
						shadow_size[s]++;
					end
				end
			end
			OP_DELETE: begin
				if (found) begin
					for (int k = p; k + 1 < shadow_size[s]; k++)
						shadow_elems[s][k] = shadow_elems[s][k+1];
					shadow_size[s]--;
				end
			end
			OP_MEMBER: begin
				add_expected(make_word(found, 0, 0, 1, 0));
				return;
			end
			OP_UNION: ov = merge_sets(s, o, ob, 1, 1, 1);
			OP_INTER: ov = merge_sets(s, o, ob, 0, 0, 1);
			OP_DIFF:  ov = merge_sets(s, o, ob, 1, 0, 0);
			OP_SYMD:  ov = merge_sets(s, o, ob, 1, 1, 0);
			OP_LIST: begin
				n = shadow_size[s];
				if (n == 0)
					add_expected(make_word(0, 0, 0, 1, 0));
				for (int k = 0; k < n; k++)
					add_expected(make_word(n, shadow_elems[s][k], 1, k + 1 == n, 0));
				return;
			end
			default: ;
		endcase
		add_expected(make_word(shadow_size[s], 0, 0, 1, ov));
	endfunction

	// hand one word to the block and wait for it to be taken
	task automatic send_word(logic [3:0] op, logic [3:0] si, logic [3:0] oi, logic [31:0] v);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, v, oi, si, op};
		do @(posedge clk); while (!s_axis_tready);
		predict_set_op(op, si, oi, v);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver: random stalls, compares each word with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = make_word(m_axis_tdata[6:0], m_axis_tdata[38:7], m_axis_tdata[39],
					m_axis_tlast, m_axis_tdata[40]);
				words_seen++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %p", $time, got);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: expected %p actual %p", $time, want, got);
						errors++;
					end
				end
			end
			if (quiet_tail) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// directed rows: extremes, every operation, self operands, out-of-range cases
	row_t directed_rows[] = '{
		'{OP_SIZE,   4'd0, 4'd0, 32'd0,         1'b1, 7'd0, 1'b0},
		'{OP_LIST,   4'd0, 4'd0, 32'd0,         1'b1, 7'd0, 1'b0},
		'{OP_MEMBER, 4'd0, 4'd0, 32'h8000_0000, 1'b1, 7'd0, 1'b0},
		'{OP_INSERT, 4'd0, 4'd0, 32'h8000_0000, 1'b1, 7'd1, 1'b0},
		'{OP_INSERT, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1, 7'd2, 1'b0},
		'{OP_INSERT, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 7'd3, 1'b0},
		'{OP_INSERT, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 7'd3, 1'b0},
		'{OP_MEMBER, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 7'd1, 1'b0},
		'{OP_LIST,   4'd0, 4'd0, 32'd0,         1'b0, 7'd0, 1'b0},
		'{OP_DELETE, 4'd0, 4'd0, 32'd5,         1'b1, 7'd3, 1'b0},
		'{OP_INSERT, 4'd15, 4'd0, 32'd0,        1'b1, 7'd1, 1'b0},
		'{OP_UNION,  4'd15, 4'd0, 32'd0,        1'b0, 7'd0, 1'b0},
		'{OP_INTER,  4'd15, 4'd0, 32'd0,        1'b0, 7'd0, 1'b0},
		'{OP_SYMD,   4'd15, 4'd0, 32'd0,        1'b0, 7'd0, 1'b0},
		'{OP_DIFF,   4'd15, 4'd0, 32'd0,        1'b0, 7'd0, 1'b0},
		'{OP_UNION,  4'd0, 4'd0, 32'd0,         1'b1, 7'd3, 1'b0},
		'{OP_INTER,  4'd0, 4'd0, 32'd0,         1'b1, 7'd3, 1'b0},
		'{OP_SYMD,   4'd0, 4'd0, 32'd0,         1'b1, 7'd0, 1'b0},
		'{OP_DELETE, 4'd15, 4'd0, 32'd0,        1'b0, 7'd0, 1'b0},
		'{4'd9,      4'd1, 4'd0, 32'd0,         1'b0, 7'd0, 1'b0},
		'{4'd15,     4'd1, 4'd0, 32'hFFFF_FFFF, 1'b0, 7'd0, 1'b0},
		'{OP_SIZE,   4'd15, 4'd15, 32'd0,       1'b0, 7'd0, 1'b0}
	};

	initial begin
		int base, n, op, s;
		logic [31:0] v;
		errors = 0;
		words_seen = 0;
		items_sent = 0;
		stall_left = 0;
		quiet_tail = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		for (int k = 0; k < SETS; k++)
			shadow_size[k] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			// typed-in expectation checked against the shadow prediction after sending
			if (directed_rows[r].check && directed_rows[r].op != OP_LIST) begin
				send_word(directed_rows[r].op, directed_rows[r].si, directed_rows[r].oi,
					directed_rows[r].val);
				if (expected_words[$].count !== directed_rows[r].count
						|| expected_words[$].overflow !== directed_rows[r].ovf) begin
					$display("%0t: row %0d expected %0d/%0b actual prediction %0d/%0b", $time, r,
						directed_rows[r].count, directed_rows[r].ovf,
						expected_words[$].count, expected_words[$].overflow);
					errors++;
				end
			end else begin
				send_word(directed_rows[r].op, directed_rows[r].si, directed_rows[r].oi,
					directed_rows[r].val);
			end
		end
		wait_drained();

		// fill set 2 to capacity then push past it: insert and union overflow
		for (int k = 0; k < CAP; k++)
			send_word(OP_INSERT, 4'd2, 4'd0, 32'(k * 3));
		send_word(OP_INSERT, 4'd2, 4'd0, 32'd1);
		for (int k = 0; k < 8; k++)
			send_word(OP_INSERT, 4'd3, 4'd0, 32'(k * 3 + 1));
		send_word(OP_UNION, 4'd3, 4'd2, 32'd0);
		send_word(OP_SYMD, 4'd2, 4'd1, 32'd0);
		send_word(OP_LIST, 4'd3, 4'd0, 32'd0);
		wait_drained();

		// random part: mostly small values in a few sets so merges overlap
		for (int it = 0; it < 112; it++) begin
			if (it == 95)
				quiet_tail = 1;
			op = $urandom_range(0, 99);
			if (op < 40)      op = OP_INSERT;
			else if (op < 52) op = OP_DELETE;
			else if (op < 62) op = OP_MEMBER;
			else if (op < 95) op = $urandom_range(3, 8);
			else              op = $urandom_range(9, 15);
			s = $urandom_range(0, 99) < 85 ? $urandom_range(0, 5) : $urandom_range(0, 15);
			v = $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 60)) - 30);
			send_word(op[3:0], s[3:0], 4'($urandom_range(0, 15)), v);
			if (it == 50)
				wait_drained();
		end
		wait_drained();

		$display("sent %0d words, checked %0d result words: all opcodes, overflow,", items_sent,
			words_seen);
		$display("self operands, unknown opcodes and random traffic with stalls");
		if (errors == 0 && expected_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
